>>> hdl/vox_pkg.sv
`default_nettype none

package vox_pkg;

	// field widths
	localparam int VersionW = 31;
	localparam int IndexW   = 31;
	localparam int CountW   = 31;

	// configuration port
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam logic [ApbAddrW-3:0] REG_EXPECTED_VERSION = '0;
	localparam logic [VersionW-1:0] VERSION_RESET = 31'd150;

	// command queue between parser and formatter
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	// result kinds
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_VOXEL      = 3'd0;
	localparam kind_t KIND_DONE       = 3'd1;
	localparam kind_t KIND_BAD_HEADER = 3'd2;
	localparam kind_t KIND_NO_PACK    = 3'd3;
	localparam kind_t KIND_NO_SIZE    = 3'd4;
	localparam kind_t KIND_NO_XYZI    = 3'd5;
	localparam kind_t KIND_TRUNCATED  = 3'd6;

	// chunk tags, little-endian as they sit in the shift word
	localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
	localparam logic [31:0] TAG_PACK = 32'h4B43_4150;
	localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
	localparam logic [31:0] TAG_XYZI = 32'h495A_5958;

	// chunk layout, byte offsets within a chunk
	localparam int HeaderLen = 20;
	localparam int PackLen   = 16;
	localparam int SizeLen   = 24;
	localparam int XyziLen   = 16;
	typedef logic [4:0] offset_t;
	localparam offset_t OFF_TAG_LAST     = 5'd3;
	localparam offset_t OFF_VERSION_LAST = 5'd7;
	localparam offset_t OFF_DIM_FIRST    = 5'd12;
	localparam offset_t OFF_DIM_SECOND   = 5'd16;
	localparam offset_t HEADER_LAST      = offset_t'(HeaderLen - 1);
	localparam offset_t PACK_LAST        = offset_t'(PackLen - 1);
	localparam offset_t SIZE_LAST        = offset_t'(SizeLen - 1);
	localparam offset_t XYZI_LAST        = offset_t'(XyziLen - 1);

	// one result, as classified by the parser, before formatting
	typedef struct packed {
		kind_t              kind;
		logic [IndexW-1:0]  model_index;
		logic [7:0]         z_raw;
		logic [7:0]         x_raw;
		logic [7:0]         y_raw;
		logic [7:0]         color_raw;
		logic signed [6:0]  center_first;
		logic signed [6:0]  center_second;
		logic               last;
	} vox_cmd_t;

	// signed byte halved, rounding toward zero
	function automatic logic signed [6:0] half_toward_zero(input logic [7:0] b);
		logic [7:0] sum;
		sum = {b[7], b[7:1]} + {7'd0, b[7] & b[0]};
		return sum[6:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/vox_in_if.sv
`default_nettype none

// byte stream channel
interface vox_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       end_of_file;

	modport source (output valid, data_byte, first_byte, end_of_file, input ready);
	modport sink   (input valid, data_byte, first_byte, end_of_file, output ready);
endinterface

`default_nettype wire

>>> hdl/vox_out_if.sv
`default_nettype none

// result channel
interface vox_out_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [30:0]       model_index;
	logic signed [8:0] pos_z;
	logic signed [8:0] pos_x;
	logic signed [7:0] pos_y;
	logic [7:0]        color_index;
	logic              last_of_model;

	modport source (output valid, kind, model_index, pos_z, pos_x, pos_y, color_index,
		last_of_model, input ready);
	modport sink   (input valid, kind, model_index, pos_z, pos_x, pos_y, color_index,
		last_of_model, output ready);
endinterface

`default_nettype wire

>>> hdl/vox_front.sv
`default_nettype none

// Byte parser: walks the chunk layout one beat at a time and pushes a
// command for every beat that yields a result.
module vox_front import vox_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [VersionW-1:0]   expected_version,
	vox_in_if.sink               in_ch,
	input  wire                  q_space,
	output logic                 q_push,
	output vox_cmd_t             q_cmd
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_HEADER    = 3'd1;
	localparam logic [2:0] PH_PACK      = 3'd2;
	localparam logic [2:0] PH_SIZE      = 3'd3;
	localparam logic [2:0] PH_XYZI      = 3'd4;
	localparam logic [2:0] PH_VOXELS    = 3'd5;
	localparam logic [2:0] PH_DONE_NEXT = 3'd6;

	logic [2:0]         phase_q, phase_d;
	offset_t            offset_q, offset_d;
	logic [31:0]        shift_q, shift_d;
	logic [CountW-1:0]  models_q, models_d;
	logic [CountW-1:0]  voxels_q, voxels_d;
	logic [IndexW-1:0]  counter_q, counter_d;
	logic signed [6:0]  cfirst_q, cfirst_d;
	logic signed [6:0]  csecond_q, csecond_d;
	logic [23:0]        vbytes_q, vbytes_d;
	logic               accept;
	logic               emit;
	vox_cmd_t           cmd;

	assign in_ch.ready = q_space;
	assign accept = in_ch.valid && q_space;
	assign q_push = accept && emit;
	assign q_cmd  = cmd;

	// next-state decode for one beat
	always_comb begin
		logic [2:0]        ph;
		offset_t           off;
		logic [CountW-1:0] cnt;
		logic [CountW-1:0] vleft;
		logic [7:0]        b;

		b = in_ch.data_byte;
		// a first byte restarts everything before the beat is parsed
		if (in_ch.first_byte) begin
			ph        = PH_HEADER;
			off       = '0;
			shift_d   = {b, 24'd0};
			models_d  = '0;
			voxels_d  = '0;
			counter_d = '0;
			cfirst_d  = '0;
			csecond_d = '0;
			vbytes_d  = '0;
		end else begin
			ph        = phase_q;
			off       = offset_q;
			shift_d   = {b, shift_q[31:8]};
			models_d  = models_q;
			voxels_d  = voxels_q;
			counter_d = counter_q;
			cfirst_d  = cfirst_q;
			csecond_d = csecond_q;
			vbytes_d  = vbytes_q;
		end
		phase_d  = ph;
		offset_d = off;
		emit     = 1'b0;
		cmd      = '0;
		cnt      = shift_d[31] ? '0 : shift_d[CountW-1:0];
		vleft    = '0;

		unique case (ph)
			PH_HEADER: begin
				offset_d = off + 5'd1;
				if (off == OFF_TAG_LAST && shift_d != TAG_VOX) begin
					emit = 1'b1; cmd.kind = KIND_BAD_HEADER; phase_d = PH_IDLE;
				end else if (off == OFF_VERSION_LAST && shift_d != {1'b0, expected_version}) begin
					emit = 1'b1; cmd.kind = KIND_BAD_HEADER; phase_d = PH_IDLE;
				end else if (off == HEADER_LAST) begin
					phase_d = PH_PACK; offset_d = '0;
				end
			end
			PH_PACK: begin
				offset_d = off + 5'd1;
				if (off == OFF_TAG_LAST && shift_d != TAG_PACK) begin
					emit = 1'b1; cmd.kind = KIND_NO_PACK; phase_d = PH_IDLE;
				end else if (off == PACK_LAST) begin
					models_d  = cnt;
					counter_d = '0;
					offset_d  = '0;
					if (cnt == '0) begin
						emit = 1'b1; cmd.kind = KIND_DONE; phase_d = PH_IDLE;
					end else begin
						phase_d = PH_SIZE;
					end
				end
			end
			PH_SIZE: begin
				offset_d = off + 5'd1;
				if (off == OFF_TAG_LAST && shift_d != TAG_SIZE) begin
					emit = 1'b1; cmd.kind = KIND_NO_SIZE; cmd.model_index = counter_d;
					phase_d = PH_IDLE;
				end else if (off == OFF_DIM_FIRST) begin
					cfirst_d = half_toward_zero(b);
				end else if (off == OFF_DIM_SECOND) begin
					csecond_d = half_toward_zero(b);
				end else if (off == SIZE_LAST) begin
					phase_d = PH_XYZI; offset_d = '0;
				end
			end
			PH_XYZI: begin
				offset_d = off + 5'd1;
				if (off == OFF_TAG_LAST && shift_d != TAG_XYZI) begin
					emit = 1'b1; cmd.kind = KIND_NO_XYZI; cmd.model_index = counter_d;
					phase_d = PH_IDLE;
				end else if (off == XYZI_LAST) begin
					voxels_d = cnt;
					offset_d = '0;
					if (cnt != '0) begin
						phase_d = PH_VOXELS;
					end else begin
						// empty model closes here
						if (models_d != '0) models_d = models_d - 1'b1;
						counter_d = counter_d + 1'b1;
						if (models_d == '0) begin
							emit = 1'b1; cmd.kind = KIND_DONE; cmd.model_index = counter_d;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_SIZE;
						end
					end
				end
			end
			PH_VOXELS: begin
				case (off[1:0])
					2'd0: begin vbytes_d[7:0]   = vbytes_d[7:0]   | b; offset_d = off + 5'd1; end
					2'd1: begin vbytes_d[15:8]  = vbytes_d[15:8]  | b; offset_d = off + 5'd1; end
					2'd2: begin vbytes_d[23:16] = vbytes_d[23:16] | b; offset_d = off + 5'd1; end
					default: begin
						vleft = (voxels_d != '0) ? voxels_d - 1'b1 : '0;
						voxels_d = vleft;
						emit = 1'b1;
						cmd.kind          = KIND_VOXEL;
						cmd.model_index   = counter_d;
						cmd.z_raw         = vbytes_d[7:0];
						cmd.x_raw         = vbytes_d[15:8];
						cmd.y_raw         = vbytes_d[23:16];
						cmd.color_raw     = b;
						cmd.center_first  = cfirst_d;
						cmd.center_second = csecond_d;
						cmd.last          = (vleft == '0);
						vbytes_d = '0;
						offset_d = '0;
						if (vleft == '0) begin
							if (models_d != '0) models_d = models_d - 1'b1;
							counter_d = counter_d + 1'b1;
							phase_d = (models_d == '0) ? PH_DONE_NEXT : PH_SIZE;
						end
					end
				endcase
			end
			PH_DONE_NEXT: begin
				emit = 1'b1; cmd.kind = KIND_DONE; cmd.model_index = counter_d;
				phase_d = PH_IDLE;
			end
			default: begin
			end
		endcase

		// end of file: a pending done is dropped, an unfinished parse is truncated
		if (in_ch.end_of_file) begin
			if (phase_d == PH_DONE_NEXT) begin
				phase_d = PH_IDLE;
			end else if (phase_d != PH_IDLE) begin
				emit = 1'b1;
				cmd = '0;
				cmd.kind = KIND_TRUNCATED;
				cmd.model_index = counter_d;
				phase_d = PH_IDLE;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			offset_q  <= '0;
			shift_q   <= '0;
			models_q  <= '0;
			voxels_q  <= '0;
			counter_q <= '0;
			cfirst_q  <= '0;
			csecond_q <= '0;
			vbytes_q  <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			offset_q  <= offset_d;
			shift_q   <= shift_d;
			models_q  <= models_d;
			voxels_q  <= voxels_d;
			counter_q <= counter_d;
			cfirst_q  <= cfirst_d;
			csecond_q <= csecond_d;
			vbytes_q  <= vbytes_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/vox_queue.sv
`default_nettype none

// Small command FIFO between parser and formatter.
module vox_queue import vox_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	input  vox_cmd_t  push_cmd,
	output logic      space,
	output logic      head_valid,
	output vox_cmd_t  head_cmd,
	input  wire       pop
);

	vox_cmd_t               entry_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q;
	logic [QueuePtrW-1:0]   rd_ptr_q;
	logic [QueuePtrW:0]     count_q;
	logic                   do_push;
	logic                   do_pop;

	assign space      = (count_q != (QueuePtrW+1)'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && space;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/vox_back.sv
`default_nettype none

// Formatter: centers voxel coordinates, adjusts the color and holds the
// result in the output register until the sink takes it.
module vox_back import vox_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       head_valid,
	input  vox_cmd_t  head_cmd,
	output logic      pop,
	vox_out_if.source out_ch
);

	logic              valid_q;
	kind_t             kind_q;
	logic [IndexW-1:0] index_q;
	logic signed [8:0] pos_z_q;
	logic signed [8:0] pos_x_q;
	logic signed [7:0] pos_y_q;
	logic [7:0]        color_q;
	logic              last_q;
	logic              is_voxel;
	logic signed [8:0] pos_z_d;
	logic signed [8:0] pos_x_d;

	assign pop = head_valid && (!valid_q || out_ch.ready);
	assign is_voxel = (head_cmd.kind == KIND_VOXEL);

	// coordinate centering
	assign pos_z_d = $signed({head_cmd.z_raw[7], head_cmd.z_raw})
		- $signed({{2{head_cmd.center_first[6]}}, head_cmd.center_first});
	assign pos_x_d = $signed({head_cmd.x_raw[7], head_cmd.x_raw})
		- $signed({{2{head_cmd.center_second[6]}}, head_cmd.center_second});

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head_cmd.kind;
			index_q <= head_cmd.model_index;
			pos_z_q <= is_voxel ? pos_z_d : '0;
			pos_x_q <= is_voxel ? pos_x_d : '0;
			pos_y_q <= is_voxel ? $signed(head_cmd.y_raw) : '0;
			color_q <= is_voxel ? head_cmd.color_raw - 8'd1 : '0;
			last_q  <= is_voxel && head_cmd.last;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.kind          = kind_q;
	assign out_ch.model_index   = index_q;
	assign out_ch.pos_z         = pos_z_q;
	assign out_ch.pos_x         = pos_x_q;
	assign out_ch.pos_y         = pos_y_q;
	assign out_ch.color_index   = color_q;
	assign out_ch.last_of_model = last_q;

endmodule

`default_nettype wire

>>> hdl/vox_voxel_stream_parser.sv
// Voxel model stream parser, one file byte per input beat.
// Throughput: one beat per cycle (combinational parser update); input stalls
// only while two commands wait in the queue behind a held result. The
// accepting edge writes the queue; the output register loads from the queue
// head once it is free. Reset: parser waits for a header, expected_version
// = 150, command queue and output register empty.
`default_nettype none

module vox_voxel_stream_parser import vox_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	vox_in_if.sink               in_ch,
	vox_out_if.source            out_ch,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [ApbAddrW-1:0]   paddr,
	input  wire [ApbDataW-1:0]   pwdata,
	output logic [ApbDataW-1:0]  prdata,
	output logic                 pready
);

	logic [VersionW-1:0] version_q;
	logic                cfg_write;
	logic                q_space;
	logic                q_push;
	vox_cmd_t            q_cmd;
	logic                head_valid;
	vox_cmd_t            head_cmd;
	logic                pop;

	// register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[ApbAddrW-1:2] == REG_EXPECTED_VERSION);
	assign prdata    = (paddr[ApbAddrW-1:2] == REG_EXPECTED_VERSION)
		? {1'b0, version_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_write) begin
			version_q <= pwdata[VersionW-1:0];
		end
	end

	vox_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.expected_version (version_q),
		.in_ch            (in_ch),
		.q_space          (q_space),
		.q_push           (q_push),
		.q_cmd            (q_cmd)
	);

	vox_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.space      (q_space),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	vox_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

`default_nettype wire
